// ===== hw/rtl/lbp_3x3_pixel_stream_macros.svh =====
// Assertion macros used by the top-level RTL file of the LBP pixel stream block.
`ifndef LBP_3X3_PIXEL_STREAM_MACROS_SVH
`define LBP_3X3_PIXEL_STREAM_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define LBPPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define LBPPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LBPPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lbpps_pkg.sv =====
// Shared types, constants and the LBP code function of the LBP pixel stream block.
package lbpps_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W_BITS  = 11;
    localparam int CFG_H_BITS  = 13;
    localparam int CFG_ADDR_W  = 1;
    localparam int DEF_MAX_WIDTH = 1024;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 13'd1024;

    // Item kinds carried in tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // 3x3 window, index = row*3 + col, row 0 is the oldest line
    typedef logic [8:0][PIX_W-1:0] win_t;

    // One line store entry: the pixel two lines up and the one a line up
    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_pair_t;

    // Neighbor positions for code bits 0..7 (center at 4 is skipped)
    localparam int unsigned LBP_POS [8] = '{0, 1, 2, 3, 5, 6, 7, 8};

    // Bit i is set when neighbor i is at least the center
    function automatic pix_t lbp_code(input win_t w);
        pix_t code;
        code = '0;
        for (int i = 0; i < 8; i++)
        begin
            code[i] = (w[LBP_POS[i]] >= w[4]);
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/lbpps_line_buf.sv =====
// Line store memory: one entry per column holding the two previous lines.
module lbpps_line_buf #(
    parameter int DEPTH  = lbpps_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  lbpps_pkg::line_pair_t  wr_data,
    output lbpps_pkg::line_pair_t  rd_data
);
    import lbpps_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t q_reg;
    line_pair_t byp_data_reg;
    logic       byp_reg;

    // Storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A write to the address read in the same cycle is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

// ===== hw/rtl/lbpps_window.sv =====
// 3x3 window registers and the LBP code of the window after the next shift.
module lbpps_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  lbpps_pkg::line_pair_t col_in,
    input  lbpps_pkg::pix_t       pix,
    output lbpps_pkg::pix_t       code,
    output lbpps_pkg::pix_t       center
);
    import lbpps_pkg::*;

    win_t win_reg;
    win_t win_next;

    // Shift every row left by one and load the new column on the right
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = col_in.upper;
        win_next[5] = col_in.middle;
        win_next[8] = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    assign code   = lbp_code(win_next);
    assign center = win_next[4];

endmodule

// ===== hw/rtl/lbp_3x3_pixel_stream.sv =====
// Top level of the 3x3 local binary pattern pixel stream block.
//
// Usage: pixels enter in raster order on the s_axis channel, one beat each,
// tuser[0] = 0 for a pixel beat and 1 for a flush beat. Once a line plus one
// pixel has gone in, every pixel beat yields one result beat on m_axis: the
// LBP code for interior pixels, the original value on border pixels, tlast
// on the frame's last pixel. Flush beats drain the owed results, one each;
// a flush with nothing owed is swallowed. The first pixel after a flush
// starts a new frame. frame_width / frame_height are written through the
// cfg port while the block is idle.
// A beat is held in the input stage and its result in the result register before it leaves m_axis.
// Throughput: one beat per cycle while the receiver does not stall, set by the line store
// memory doing one read and one write per cycle, feeding the window register and the result register.
// Reset clears counters, window and registers (1024 x 1024); the line
// store keeps whatever it held. When the receiver stalls, the result
// register holds its beat and one more beat stays in the input stage;
// s_axis_tready then drops until m_axis_tready returns.
`include "lbp_3x3_pixel_stream_macros.svh"

module lbp_3x3_pixel_stream #(
    parameter int MAX_WIDTH = lbpps_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [lbpps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lbpps_pkg::CFG_H_BITS-1:0]  cfg_wdata,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]                        s_axis_tuser,   // [0] op
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] result_pixel
    output logic                              m_axis_tlast
);
    import lbpps_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CMP_W     = ((COL_W > CFG_W_BITS) ? COL_W : CFG_W_BITS) + 1;
    localparam int ROW_CMP_W = CFG_H_BITS + 1;

    // Configuration registers
    logic [CFG_W_BITS-1:0] fw_reg;
    logic [CFG_H_BITS-1:0] fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= FRAME_WIDTH_RST;
            fh_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  fw_reg <= cfg_wdata[CFG_W_BITS-1:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    // Effective frame size: zero acts as one, width clamped to the store depth
    logic [CMP_W-1:0]     eff_w;
    logic [ROW_CMP_W-1:0] eff_h;
    logic [CMP_W-1:0]     lag;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = CMP_W'(1);
        end
        else if (CMP_W'(fw_reg) > CMP_W'(MAX_WIDTH))
        begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CMP_W'(fw_reg);
        end
        eff_h = (fh_reg == '0) ? ROW_CMP_W'(1) : ROW_CMP_W'(fh_reg);
        lag   = eff_w + CMP_W'(1);
    end

    // Stream state
    logic [COL_W-1:0]      in_col_reg,  in_col_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [CFG_H_BITS-1:0] out_row_reg, out_row_next;
    logic [CMP_W-1:0]      pend_reg,    pend_next;
    logic                  drain_reg,   drain_next;

    // Input stage and output registers
    logic             s1_valid_reg, s1_emit_reg, s1_inner_reg, s1_last_reg;
    pix_t             s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             m_valid_reg;
    pix_t             m_data_reg;
    logic             m_last_reg;

    logic s1_advance;
    logic accept;
    logic is_flush;
    logic restart;
    logic drop;
    logic live;
    logic do_emit;
    logic inner;
    logic last;

    logic [COL_W-1:0]      col_base;
    logic [COL_W-1:0]      col;
    logic [CMP_W-1:0]      col_inc;
    logic [COL_W-1:0]      ocol_base;
    logic [CFG_H_BITS-1:0] orow_base;
    logic [CMP_W-1:0]      ocol_inc;
    logic [ROW_CMP_W-1:0]  orow_inc;
    logic [CMP_W-1:0]      pend_base;

    assign s1_advance    = !s1_valid_reg || !s1_emit_reg || !m_valid_reg || m_axis_tready;
    assign s_axis_tready = s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Beat decode: a pixel after a flush restarts the frame
    always_comb
    begin
        is_flush  = (s_axis_tuser[0] == OP_FLUSH);
        restart   = !is_flush && drain_reg;
        drop      = is_flush && (pend_reg == '0);
        live      = accept && !drop;

        col_base  = restart ? '0 : in_col_reg;
        ocol_base = restart ? '0 : out_col_reg;
        orow_base = restart ? '0 : out_row_reg;
        pend_base = restart ? '0 : pend_reg;

        col       = (CMP_W'(col_base) >= eff_w) ? '0 : col_base;
        col_inc   = CMP_W'(col) + CMP_W'(1);
        ocol_inc  = CMP_W'(ocol_base) + CMP_W'(1);
        orow_inc  = ROW_CMP_W'(orow_base) + ROW_CMP_W'(1);

        do_emit   = is_flush || (pend_base >= lag);
        inner     = (orow_base != '0) && (orow_inc < eff_h)
                 && (ocol_base != '0) && (ocol_inc < eff_w);
        last      = (orow_inc >= eff_h) && (ocol_inc >= eff_w);
    end

    // Counter updates
    always_comb
    begin
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        drain_next   = drain_reg;
        if (live)
        begin
            in_col_next = (col_inc >= eff_w) ? '0 : col_inc[COL_W-1:0];
            drain_next  = is_flush;
            if (is_flush)
            begin
                pend_next = pend_base - CMP_W'(1);
            end
            else if (do_emit)
            begin
                pend_next = lag;
            end
            else
            begin
                pend_next = pend_base + CMP_W'(1);
            end
            if (do_emit)
            begin
                out_col_next = (ocol_inc >= eff_w) ? '0 : ocol_inc[COL_W-1:0];
                if (ocol_inc >= eff_w)
                begin
                    out_row_next = (orow_inc >= eff_h) ? '0 : orow_inc[CFG_H_BITS-1:0];
                end
                else
                begin
                    out_row_next = orow_base;
                end
            end
            else
            begin
                out_col_next = ocol_base;
                out_row_next = orow_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            drain_reg   <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            drain_reg   <= drain_next;
        end
    end

    // Input stage: holds the beat while its line store read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (live)
        begin
            s1_emit_reg  <= do_emit;
            s1_inner_reg <= inner;
            s1_last_reg  <= last;
            s1_pix_reg   <= is_flush ? '0 : s_axis_tdata;
            s1_addr_reg  <= col;
        end
    end

    // Line store and window
    line_pair_t rd_pair;
    line_pair_t wr_pair;
    logic       shift_en;
    pix_t       code;
    pix_t       center;

    assign shift_en       = s1_valid_reg && s1_advance;
    assign wr_pair.upper  = rd_pair.middle;
    assign wr_pair.middle = s1_pix_reg;

    lbpps_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (live),
        .rd_addr (col),
        .wr_en   (shift_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_pair),
        .rd_data (rd_pair)
    );

    lbpps_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .col_in   (rd_pair),
        .pix      (s1_pix_reg),
        .code     (code),
        .center   (center)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (shift_en && s1_emit_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en && s1_emit_reg)
        begin
            m_data_reg <= s1_inner_reg ? code : center;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Checks
    `LBPPS_ASSERT_ALWAYS(a_pend_bound, pend_reg <= CMP_W'(MAX_WIDTH + 1), "owed count above depth")
    `LBPPS_ASSERT_IMPL(a_out_source, $rose(m_axis_tvalid), $past(s1_valid_reg && s1_emit_reg), "result beat without an emitting input stage")
    `LBPPS_ASSERT_NEXT(a_flush_swallow, accept && is_flush && (pend_reg == '0), !s1_valid_reg, "empty flush entered the pipeline")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 3x3 LBP pixel stream block: random stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    import lbpps_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STIM_TARGET   = 850;
    localparam int SAFE_COLS     = 40;    // columns primed early on; narrow frames stay within
    localparam int MAX_FRAME_PIX = 160;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 5000000;

    typedef struct packed {
        logic op;
        pix_t pix;
    } stim_beat_t;

    typedef struct packed {
        pix_t code;
        logic last;
    } lbp_beat_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr       = '0;
    logic [CFG_H_BITS-1:0] cfg_wdata      = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata   = '0;    // [7:0] pixel
    logic [0:0]            s_axis_tuser   = '0;    // [0] op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [7:0]            m_axis_tdata;           // [7:0] result_pixel
    logic                  m_axis_tlast;

    // stimulus and scoreboard
    stim_beat_t  pending_beats [$];
    lbp_beat_t   owed_results [$];
    int unsigned beats_queued   = 0;
    int unsigned beats_accepted = 0;
    int unsigned stim_count     = 0;
    int unsigned mismatch_count = 0;

    // idling control, set per phase
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned src_gap        = 0;
    int unsigned sink_gap       = 0;
    logic        hold_req       = 1'b0;
    int unsigned hold_left      = 0;
    stim_beat_t  drv_beat;
    lbp_beat_t   mon_got;
    lbp_beat_t   mon_want;

    // predictor state
    pix_t                  upper_line  [DEF_MAX_WIDTH];
    pix_t                  middle_line [DEF_MAX_WIDTH];
    pix_t                  window_px   [9];
    int unsigned           in_col, in_row, out_col, out_row;
    int unsigned           owed_cnt;
    bit                    flush_seen;
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;

    lbp_3x3_pixel_stream DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // effective frame size after clipping
    function automatic int unsigned frame_cols();
        if (width_reg == '0)
            return 1;
        if (width_reg > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    // push one pixel through the line stores and the window
    function automatic void lbp_shift_in(input pix_t v);
        int unsigned cols;
        int unsigned c;
        pix_t        top;
        pix_t        mid;
        int          r;
        cols = frame_cols();
        c = (in_col >= cols) ? 0 : in_col;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = v;
        for (r = 0; r < 3; r++)
        begin
            window_px[r * 3]     = window_px[r * 3 + 1];
            window_px[r * 3 + 1] = window_px[r * 3 + 2];
        end
        window_px[2] = top;
        window_px[5] = mid;
        window_px[8] = v;
        if (c + 1 >= cols)
        begin
            in_col = 0;
            in_row = (in_row + 1 >= frame_rows()) ? 0 : in_row + 1;
        end
        else
            in_col = c + 1;
    endfunction

    // code of the window center; border pixels keep their value
    function automatic lbp_beat_t lbp_next_result();
        lbp_beat_t   res;
        int unsigned cols;
        int unsigned rows;
        int unsigned pos;
        pix_t        ctr;
        int          i;
        cols = frame_cols();
        rows = frame_rows();
        ctr = window_px[4];
        res.code = ctr;
        if (out_row >= 1 && out_row + 1 < rows && out_col >= 1 && out_col + 1 < cols)
        begin
            for (i = 0; i < 8; i++)
            begin
                pos = (i < 4) ? i : i + 1;
                res.code[i] = (window_px[pos] >= ctr);
            end
        end
        res.last = (out_row + 1 >= rows) && (out_col + 1 >= cols);
        if (out_col + 1 >= cols)
        begin
            out_col = 0;
            out_row = (out_row + 1 >= rows) ? 0 : out_row + 1;
        end
        else
            out_col++;
        return res;
    endfunction

    // predict the result of one accepted input beat
    function automatic void lbp_accept_beat(input logic op, input pix_t pix);
        int unsigned lag;
        lag = frame_cols() + 1;
        if (op == OP_FLUSH)
        begin
            // nothing owed: swallowed
            if (owed_cnt != 0)
            begin
                flush_seen = 1'b1;
                lbp_shift_in('0);
                owed_results.push_back(lbp_next_result());
                owed_cnt--;
            end
        end
        else
        begin
            // first pixel after a flush opens a new frame
            if (flush_seen)
            begin
                flush_seen = 1'b0;
                owed_cnt = 0;
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end
            lbp_shift_in(pix);
            if (owed_cnt >= lag)
            begin
                owed_cnt = lag;
                owed_results.push_back(lbp_next_result());
            end
            else
                owed_cnt++;
        end
        beats_accepted++;
    endfunction

    function automatic void flag_mismatch(input string what, input lbp_beat_t want,
                                          input lbp_beat_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected code %0d last %0b, got code %0d last %0b",
                     what, $realtime, want.code, want.last, got.code, got.last);
    endfunction

    function automatic pix_t pick_pixel(input int unsigned style, input pix_t base);
        case (style)
            0: return pix_t'($urandom_range(255));
            1: return base + pix_t'($urandom_range(3));    // narrow band, many ties
            2: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return base;                          // flat area
        endcase
    endfunction

    task automatic queue_beat(input logic op, input pix_t pix);
        stim_beat_t b;
        b.op = op;
        b.pix = pix;
        pending_beats.push_back(b);
        beats_queued++;
        stim_count++;
    endtask

    task automatic queue_pixels(input int unsigned n, input int unsigned style);
        pix_t base;
        base = pix_t'($urandom_range(255));
        repeat (n)
            queue_beat(OP_PIXEL, pick_pixel(style, base));
    endtask

    task automatic queue_flushes(input int unsigned n);
        repeat (n)
            queue_beat(OP_FLUSH, pix_t'($urandom_range(255)));
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_H_BITS-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = value[CFG_W_BITS-1:0];
        else
            height_reg = value[CFG_H_BITS-1:0];
    endtask

    // wait until every beat is in and every result is out, then let the pipe empty
    task automatic settle();
        while (beats_accepted != beats_queued || owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input driver: holds a beat until taken, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                lbp_accept_beat(s_axis_tuser[0], s_axis_tdata);

            if (s_axis_tvalid && !s_axis_tready)
            begin
                // beat still waiting
            end
            else if (src_gap != 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
            begin
                src_gap       <= $urandom_range(17);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                drv_beat = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drv_beat.pix;
                s_axis_tuser  <= drv_beat.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // output monitor: compares each result beat with the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                mon_got.code = m_axis_tdata;
                mon_got.last = m_axis_tlast;
                if (owed_results.size() == 0)
                    flag_mismatch("unowed result", '0, mon_got);
                else
                begin
                    mon_want = owed_results.pop_front();
                    if (mon_got.code !== mon_want.code)
                        flag_mismatch("result_pixel", mon_want, mon_got);
                    else if (mon_got.last !== mon_want.last)
                        flag_mismatch("frame_last", mon_want, mon_got);
                end
            end

            if (hold_left != 0)
                m_axis_tready <= 1'b0;
            else if (sink_gap != 0)
            begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct)
            begin
                sink_gap      <= $urandom_range(17);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // stimulus sequence
    initial
    begin
        int unsigned kind;
        int unsigned cols;
        int unsigned rows;
        int unsigned ecols;
        int unsigned n;
        int          i;

        for (i = 0; i < DEF_MAX_WIDTH; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (i = 0; i < 9; i++)
            window_px[i] = '0;
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        owed_cnt   = 0;
        flush_seen = 1'b0;
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: swallowed flush, then a 4x3 frame of extremes and ties, drained
        src_idle_pct   = 20;
        sink_stall_pct = 20;
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 3);
        queue_beat(OP_FLUSH, 8'hFF);
        queue_beat(OP_PIXEL, 8'd0);
        queue_beat(OP_PIXEL, 8'd255);
        queue_beat(OP_PIXEL, 8'd7);
        queue_beat(OP_PIXEL, 8'd255);
        queue_beat(OP_PIXEL, 8'd255);
        queue_beat(OP_PIXEL, 8'd7);
        queue_beat(OP_PIXEL, 8'd7);
        queue_beat(OP_PIXEL, 8'd0);
        queue_beat(OP_PIXEL, 8'd7);
        queue_beat(OP_PIXEL, 8'd0);
        queue_beat(OP_PIXEL, 8'd255);
        queue_beat(OP_PIXEL, 8'd128);
        queue_flushes(6);
        settle();

        // full 3-row frame over the safe columns; receiver holds off meanwhile
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(REG_FRAME_WIDTH, SAFE_COLS);
        write_reg(REG_FRAME_HEIGHT, 3);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        queue_pixels(3 * SAFE_COLS, 1);
        queue_flushes(SAFE_COLS + 1);
        settle();

        while (stim_count < STIM_TARGET)
        begin
            src_idle_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            sink_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
            kind = $urandom_range(99);
            if (kind < 10 && flush_seen)
            begin
                // wide frame: short head only, drained right away
                case ($urandom_range(2))
                    0: cols = DEF_MAX_WIDTH;
                    1: cols = 2047;    // above the maximum, clipped
                    default: cols = $urandom_range(SAFE_COLS + 1, DEF_MAX_WIDTH - 1);
                endcase
                rows = $urandom_range(1) ? 4096 : $urandom_range(3);
                write_reg(REG_FRAME_WIDTH, cols);
                write_reg(REG_FRAME_HEIGHT, rows);
                n = $urandom_range(1, 16);
                queue_pixels(n, $urandom_range(3));
                queue_flushes(n + 1);
            end
            else if (kind < 25)
            begin
                // noise: pixels and flushes mixed on a narrow frame
                write_reg(REG_FRAME_WIDTH, $urandom_range(8));
                write_reg(REG_FRAME_HEIGHT, $urandom_range(5));
                n = $urandom_range(10, 40);
                repeat (n)
                begin
                    if ($urandom_range(3) == 0)
                        queue_flushes(1);
                    else
                        queue_pixels(1, 0);
                end
            end
            else
            begin
                // well-formed frames with random content
                case ($urandom_range(9))
                    0: cols = 0;
                    1: cols = 1;
                    2: cols = 2;
                    3: cols = SAFE_COLS;
                    default: cols = $urandom_range(3, 12);
                endcase
                case ($urandom_range(9))
                    0: rows = 0;
                    1: rows = 1;
                    2: rows = 2;
                    3: rows = 4096;
                    default: rows = $urandom_range(3, 6);
                endcase
                write_reg(REG_FRAME_WIDTH, cols);
                write_reg(REG_FRAME_HEIGHT, rows);
                ecols = (cols == 0) ? 1 : cols;
                n = ecols * ((rows == 0) ? 1 : rows);
                if (n > MAX_FRAME_PIX)
                    n = MAX_FRAME_PIX;
                if ($urandom_range(4) == 0)
                    n = n * 2;
                queue_pixels(n, $urandom_range(3));
                case ($urandom_range(9))
                    7: queue_flushes($urandom_range(1, ecols));    // partial drain
                    8: ;                                            // frame left open
                    9:
                    begin
                        repeat ($urandom_range(5, 20))
                        begin
                            if ($urandom_range(2) == 0)
                                queue_flushes(1);
                            else
                                queue_pixels(1, 0);
                        end
                    end
                    default: queue_flushes(ecols + 1 + $urandom_range(2));
                endcase
            end
            settle();
        end

        // closing frame with no idling on either side
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_reg(REG_FRAME_WIDTH, 5);
        write_reg(REG_FRAME_HEIGHT, 4);
        queue_pixels(20, 0);
        queue_flushes(6);
        settle();

        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit
    initial
    begin
        #RUN_LIMIT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
